[design/tblim_pkg.sv]
// Package of the two-level token bucket limiter.
// Holds widths, reset values, register indexes, codes and the controller/datapath structs.
// No dependencies.
package tblim_pkg;

	localparam int NUM_CATEGORIES_DEF = 6;

	localparam int CAT_W   = 3;
	localparam int TIME_W  = 32;
	localparam int TOK_W   = 16;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W  = TIME_W + TOK_W;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [TOK_W-1:0] GLOBAL_CAP_RST = 16'd1000;
	localparam logic [TOK_W-1:0] CAT_CAP_RST    = 16'd200;
	localparam logic [TOK_W-1:0] TPR_RST        = 16'd100;
	localparam logic [TOK_W-1:0] INTERVAL_RST   = 16'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_CAP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAT_CAP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TPR        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd4;

	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_GLOBAL   = 2'd1;
	localparam logic [1:0] CAUSE_CATEGORY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic fetch;
		logic sel_cat;
		logic div_start;
		logic mul;
		logic upd;
		logic spend;
		logic reject;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic en;
		logic cat_ok;
		logic due;
		logic div_done;
		logic tok_zero;
	} sts_t;

endpackage

[design/tblim_div.sv]
// Restoring divider of the limiter: 32-bit elapsed time by 16-bit interval, one bit a cycle.
// Depends on tblim_pkg.
module tblim_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tblim_pkg::TIME_W-1:0]  dividend,
	input  logic [tblim_pkg::TOK_W-1:0]   divisor,
	output logic                          done,
	output logic [tblim_pkg::TIME_W-1:0]  quot
);
	import tblim_pkg::*;

	localparam int STEP_W = $clog2(TIME_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] quo_q;
	logic [TOK_W-1:0]  rem_q;
	logic [TOK_W:0]    trial;
	logic              fits;

	assign trial = {rem_q, quo_q[TIME_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(TIME_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[TIME_W-2:0], fits};
			rem_q <= fits ? TOK_W'(trial - {1'b0, divisor}) : trial[TOK_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[design/tblim_dp.sv]
// Datapath of the limiter: configuration registers, global bucket, category row memory,
// refill arithmetic and the result register. Depends on tblim_pkg and tblim_div.
module tblim_dp #(
	parameter int NUM_CATEGORIES = tblim_pkg::NUM_CATEGORIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tblim_pkg::cmd_t                  cmd,
	output tblim_pkg::sts_t                  sts,
	input  logic [tblim_pkg::CAT_W-1:0]      in_category,
	input  logic [tblim_pkg::TIME_W-1:0]     in_now_ms,
	input  logic                             cfg_we,
	input  logic [tblim_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tblim_pkg::CFG_W-1:0]      cfg_data,
	output logic                             out_allowed,
	output logic [1:0]                       out_reject_cause,
	output logic [tblim_pkg::CNT_W-1:0]      out_throttled_count
);
	import tblim_pkg::*;

	localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

	typedef struct packed {
		logic [TOK_W-1:0]  tokens;
		logic [TIME_W-1:0] refill_time;
		logic [CNT_W-1:0]  total;
	} row_t;

	logic                enable_q;
	logic [TOK_W-1:0]    gcap_q;
	logic [TOK_W-1:0]    ccap_q;
	logic [TOK_W-1:0]    tpr_q;
	logic [TOK_W-1:0]    interval_q;

	logic [TOK_W-1:0]    gtok_q;
	logic [TIME_W-1:0]   gtime_q;

	row_t                mem_q [NUM_CATEGORIES];
	logic [NUM_CATEGORIES-1:0] vld_q;
	row_t                rd_q;
	logic                rd_vld_q;

	logic [IDX_W-1:0]    idx_q;
	logic                cat_ok_q;
	logic [TIME_W-1:0]   now_q;
	logic [TOK_W-1:0]    ctok_q;
	logic [TIME_W-1:0]   ctime_q;
	logic [CNT_W-1:0]    ctotal_q;
	logic                allowed_q;
	logic [1:0]          cause_q;
	logic [PROD_W-1:0]   prod_q;

	logic                in_cat_ok;
	logic [IDX_W-1:0]    in_idx;
	logic [TOK_W-1:0]    interval_eff;
	logic [TIME_W-1:0]   last_sel;
	logic [TIME_W-1:0]   elapsed;
	logic [TOK_W-1:0]    tok_sel;
	logic [TOK_W-1:0]    cap_sel;
	logic [PROD_W:0]     level;
	logic [TOK_W-1:0]    tok_new;
	logic                div_done;
	logic [TIME_W-1:0]   quot;

	assign in_cat_ok    = 32'(in_category) < 32'(NUM_CATEGORIES);
	assign in_idx       = IDX_W'(in_category);
	assign interval_eff = (interval_q == '0) ? TOK_W'(1) : interval_q;
	assign last_sel     = cmd.sel_cat ? ctime_q : gtime_q;
	assign elapsed      = now_q - last_sel;
	assign tok_sel      = cmd.sel_cat ? ctok_q : gtok_q;
	assign cap_sel      = cmd.sel_cat ? ccap_q : gcap_q;
	assign level        = (PROD_W + 1)'(tok_sel) + (PROD_W + 1)'(prod_q);
	assign tok_new      = (level > (PROD_W + 1)'(cap_sel)) ? cap_sel : level[TOK_W-1:0];

	tblim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (elapsed),
		.divisor  (interval_eff),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		sts.en       = enable_q;
		sts.cat_ok   = cat_ok_q;
		sts.due      = elapsed >= TIME_W'(interval_eff);
		sts.div_done = div_done;
		sts.tok_zero = tok_sel == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b1;
			gcap_q     <= GLOBAL_CAP_RST;
			ccap_q     <= CAT_CAP_RST;
			tpr_q      <= TPR_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     enable_q   <= cfg_data[0];
				REG_GLOBAL_CAP: gcap_q     <= cfg_data;
				REG_CAT_CAP:    ccap_q     <= cfg_data;
				REG_TPR:        tpr_q      <= cfg_data;
				REG_INTERVAL:   interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gtok_q  <= GLOBAL_CAP_RST;
			gtime_q <= '0;
			vld_q   <= '0;
		end else begin
			if (!cmd.sel_cat) begin
				if (cmd.upd) begin
					gtok_q  <= tok_new;
					gtime_q <= now_q;
				end else if (cmd.spend) begin
					gtok_q <= gtok_q - 1'b1;
				end
			end
			if (cmd.finish && enable_q && cat_ok_q) begin
				vld_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && in_cat_ok) begin
			rd_q     <= mem_q[in_idx];
			rd_vld_q <= vld_q[in_idx];
		end
		if (cmd.finish && enable_q && cat_ok_q) begin
			mem_q[idx_q] <= '{tokens: ctok_q, refill_time: ctime_q, total: ctotal_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q     <= in_idx;
			cat_ok_q  <= in_cat_ok;
			now_q     <= in_now_ms;
			allowed_q <= 1'b1;
			cause_q   <= CAUSE_NONE;
		end
		if (cmd.fetch) begin
			ctok_q   <= rd_vld_q ? rd_q.tokens      : CAT_CAP_RST;
			ctime_q  <= rd_vld_q ? rd_q.refill_time : '0;
			ctotal_q <= rd_vld_q ? rd_q.total       : '0;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(quot) * PROD_W'(tpr_q);
		end
		if (cmd.sel_cat) begin
			if (cmd.upd) begin
				ctok_q  <= tok_new;
				ctime_q <= now_q;
			end else if (cmd.spend) begin
				ctok_q <= ctok_q - 1'b1;
			end
		end
		if (cmd.reject) begin
			allowed_q <= 1'b0;
			cause_q   <= cmd.sel_cat ? CAUSE_CATEGORY : CAUSE_GLOBAL;
			if (cat_ok_q && (ctotal_q != '1)) begin
				ctotal_q <= ctotal_q + 1'b1;
			end
		end
		if (cmd.finish) begin
			out_allowed         <= allowed_q;
			out_reject_cause    <= cause_q;
			out_throttled_count <= cat_ok_q ? ctotal_q : '0;
		end
	end

endmodule

[design/tblim_ctrl.sv]
// Controller of the limiter: sequences fetch, refill, decide and finish over both buckets.
// Depends on tblim_pkg; drives tblim_dp through cmd_t and reads sts_t.
module tblim_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tblim_pkg::cmd_t  cmd,
	input  tblim_pkg::sts_t  sts
);
	import tblim_pkg::*;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_FETCH;
					phase_d = 1'b0;
				end
			end
			ST_FETCH: state_d = ST_CHECK;
			ST_CHECK: begin
				if (!sts.en) state_d = ST_FINISH;
				else if (sts.due) state_d = ST_DIV;
				else state_d = ST_DECIDE;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_UPD;
			ST_UPD: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (!sts.tok_zero && !phase_q && sts.cat_ok) begin
					state_d = ST_CHECK;
					phase_d = 1'b1;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.sel_cat   = phase_q;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.fetch     = state_q == ST_FETCH;
		cmd.div_start = (state_q == ST_CHECK) && sts.en && sts.due;
		cmd.mul       = state_q == ST_MUL;
		cmd.upd       = state_q == ST_UPD;
		cmd.spend     = (state_q == ST_DECIDE) && !sts.tok_zero;
		cmd.reject    = (state_q == ST_DECIDE) && sts.tok_zero;
		cmd.finish    = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

[design/two_level_token_bucket_limiter.sv]
// Top level of the two-level token bucket limiter: streaming ports and configuration port.
// Depends on tblim_pkg, tblim_ctrl, tblim_dp (with tblim_div).
//
// channel  direction  handshake             payload
// s_*      in         s_tvalid / s_tready   s_tdata: category[2:0], now_ms[34:3]
// m_*      out        m_tvalid / m_tready   m_tdata: allowed[0], reject_cause[2:1], count[34:3]
// cfg_*    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A disabled item goes from fetch and check to finish; else each bucket runs check, then, when due, the
// bit-serial divider, multiply and update, then decide (category bucket only after a global pass).
// Reset leaves both levels full, refill times zero and category rows marked unwritten.
// One item is in flight at a time; a held result stalls the next only at its finish.
// Configuration writes are taken every cycle.
module two_level_token_bucket_limiter #(
	parameter int NUM_CATEGORIES = tblim_pkg::NUM_CATEGORIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tblim_pkg::S_DATA_W-1:0]    s_tdata,   // category, now_ms, zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tblim_pkg::M_DATA_W-1:0]    m_tdata,   // allowed, reject_cause, throttled_count, zero fill
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tblim_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tblim_pkg::CFG_W-1:0]       cfg_data
);
	import tblim_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic             out_allowed;
	logic [1:0]       out_reject_cause;
	logic [CNT_W-1:0] out_throttled_count;

	assign cfg_ready = 1'b1;

	tblim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tblim_dp #(
		.NUM_CATEGORIES (NUM_CATEGORIES)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.in_category         (s_tdata[CAT_W-1:0]),
		.in_now_ms           (s_tdata[CAT_W+TIME_W-1:CAT_W]),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.out_allowed         (out_allowed),
		.out_reject_cause    (out_reject_cause),
		.out_throttled_count (out_throttled_count)
	);

	assign m_tdata = {(M_DATA_W - 3 - CNT_W)'(0), out_throttled_count, out_reject_cause,
		out_allowed};

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in flight");

	a_allowed_matches_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == CAUSE_NONE)))
		else $error("allowed flag disagrees with reject cause");

	a_cause_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:1] == CAUSE_NONE || m_tdata[2:1] == CAUSE_GLOBAL ||
			m_tdata[2:1] == CAUSE_CATEGORY))
		else $error("illegal reject cause");

	a_spend_xor_reject: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.spend && cmd.reject))
		else $error("bucket spent and rejected at once");
`endif

endmodule

[test/tb_two_level_token_bucket_limiter.sv]
// Self-checking bench for the two-level token bucket limiter: directed events, then random ones.
// Predicts each verdict from its own bucket state and compares every field of every result.
// Depends on tblim_pkg and two_level_token_bucket_limiter.
module tb_two_level_token_bucket_limiter;
	import tblim_pkg::*;

	localparam int NCAT        = NUM_CATEGORIES_DEF;
	localparam int CYCLE_LIMIT = 800000;

	typedef struct packed {
		logic        allowed;
		logic [1:0]  cause;
		logic [31:0] count;
	} verdict_t;

	class verdict_board;
		logic        en;
		logic [15:0] gcap, ccap, rate, interval;
		logic [15:0] gtok;
		logic [31:0] gstamp;
		logic [15:0] ctok [NCAT];
		logic [31:0] cstamp [NCAT];
		logic [31:0] throttled [NCAT];
		verdict_t    due_q [$];
		int          errors;

		function new();
			en       = 1'b1;
			gcap     = GLOBAL_CAP_RST;
			ccap     = CAT_CAP_RST;
			rate     = TPR_RST;
			interval = INTERVAL_RST;
			gtok     = GLOBAL_CAP_RST;
			gstamp   = '0;
			for (int c = 0; c < NCAT; c++) begin
				ctok[c]      = CAT_CAP_RST;
				cstamp[c]    = '0;
				throttled[c] = '0;
			end
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			case (idx)
				REG_ENABLE:     en = val[0];
				REG_GLOBAL_CAP: gcap = val;
				REG_CAT_CAP:    ccap = val;
				REG_TPR:        rate = val;
				REG_INTERVAL:   interval = val;
				default: ;
			endcase
		endfunction

		function void refill(inout logic [15:0] tok, inout logic [31:0] stamp,
				input logic [15:0] cap, input logic [31:0] now);
			logic [31:0] elapsed, ivl;
			logic [63:0] level;
			elapsed = now - stamp;
			ivl = (interval == 16'd0) ? 32'd1 : {16'd0, interval};
			if (elapsed >= ivl) begin
				level = {48'd0, tok} + {32'd0, elapsed / ivl} * {48'd0, rate};
				tok   = (level > {48'd0, cap}) ? cap : level[15:0];
				stamp = now;
			end
		endfunction

		function void bump(logic [2:0] cat);
			if (throttled[cat] != 32'hFFFF_FFFF)
				throttled[cat]++;
		endfunction

		function void note_event(logic [2:0] cat, logic [31:0] now);
			verdict_t v;
			logic     hit;
			hit       = (cat < NCAT);
			v.allowed = 1'b1;
			v.cause   = CAUSE_NONE;
			if (en) begin
				refill(gtok, gstamp, gcap, now);
				if (gtok == 16'd0) begin
					v.allowed = 1'b0;
					v.cause   = CAUSE_GLOBAL;
					if (hit)
						bump(cat);
				end else begin
					gtok--;
					if (hit) begin
						refill(ctok[cat], cstamp[cat], ccap, now);
						if (ctok[cat] == 16'd0) begin
							v.allowed = 1'b0;
							v.cause   = CAUSE_CATEGORY;
							bump(cat);
						end else begin
							ctok[cat]--;
						end
					end
				end
			end
			v.count = hit ? throttled[cat] : 32'd0;
			due_q.push_back(v);
		endfunction

		function void check_result(logic [M_DATA_W-1:0] d);
			verdict_t want;
			if (due_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, d);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (d[0] !== want.allowed) begin
				$display("%0t allowed: expected %0d, actual %0d", $time, want.allowed, d[0]);
				errors++;
			end
			if (d[2:1] !== want.cause) begin
				$display("%0t reject_cause: expected %0d, actual %0d", $time, want.cause, d[2:1]);
				errors++;
			end
			if (d[34:3] !== want.count) begin
				$display("%0t throttled_count: expected %0d, actual %0d", $time, want.count,
					d[34:3]);
				errors++;
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	verdict_board board = new();
	int           src_idle_pct = 23;
	int           sink_idle_pct = 23;
	int           cycles = 0;

	two_level_token_bucket_limiter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[two_level_token_bucket_limiter] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_event(input logic [2:0] cat, input logic [31:0] now);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, now, cat};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_event(cat, now);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic apply_settings(input logic [15:0] en, gcap, ccap, rate, ivl);
		write_reg(REG_ENABLE, en);
		write_reg(REG_GLOBAL_CAP, gcap);
		write_reg(REG_CAT_CAP, ccap);
		write_reg(REG_TPR, rate);
		write_reg(REG_INTERVAL, ivl);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_events(input int count, input int max_step, input int hot_pct);
		logic [31:0] now;
		logic [2:0]  hot, cat;
		int          roll;
		now = $urandom();
		hot = 3'($urandom_range(0, NCAT - 1));
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 5)
				now = $urandom();
			else if (roll >= 10)
				now += $urandom_range(0, max_step);
			if ($urandom_range(99) < 5)
				hot = 3'($urandom_range(0, NCAT - 1));
			cat = ($urandom_range(99) < hot_pct) ? hot : 3'($urandom_range(0, 7));
			send_event(cat, now);
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_ENABLE;
		cfg_data  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset levels, time extremes, categories out of range
		send_event(3'd0, 32'd0);
		send_event(3'd5, 32'hFFFF_FFFF);
		send_event(3'd6, 32'hFFFF_FFFF);
		send_event(3'd7, 32'd5);
		drain();

		// lowered capacities, zero interval, empty global and category buckets
		apply_settings(16'd1, 16'd4, 16'd2, 16'd1, 16'd0);
		send_event(3'd2, 32'hFFFF_FFFF);
		repeat (4) send_event(3'd0, 32'd1000);
		send_event(3'd1, 32'd1000);
		send_event(3'd1, 32'd1000);
		send_event(3'd7, 32'd1000);
		send_event(3'd0, 32'd1001);
		send_event(3'd6, 32'd1001);
		drain();

		// disabled: everything passes, counts reported
		apply_settings(16'd0, 16'd4, 16'd2, 16'd1, 16'd0);
		send_event(3'd0, 32'd5000);
		send_event(3'd1, 32'd1000);
		send_event(3'd7, 32'd0);
		drain();

		apply_settings(16'd1, 16'd30, 16'd3, 16'd2, 16'd20);
		run_events(150, 4, 50);
		drain();
		run_events(150, 4, 50);
		drain();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
		run_events(250, 3, 30);
		drain();
		src_idle_pct  = 23;
		sink_idle_pct = 23;

		apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
		run_events(250, 40000, 40);
		drain();

		apply_settings(16'd0, 16'd10, 16'd3, 16'd1, 16'd5);
		run_events(150, 6, 40);
		drain();

		repeat (3) begin
			apply_settings(16'd1, 16'($urandom_range(1, 64)), 16'($urandom_range(1, 16)),
				16'($urandom_range(1, 8)), 16'($urandom_range(1, 64)));
			run_events(200, 8, 60);
			drain();
		end

		repeat (100) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("[two_level_token_bucket_limiter] OK");
		else
			$display("[two_level_token_bucket_limiter] ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/tblim_pkg.sv
design/tblim_div.sv
design/tblim_dp.sv
design/tblim_ctrl.sv
design/two_level_token_bucket_limiter.sv
test/tb_two_level_token_bucket_limiter.sv
